// ----- rtl/ndlp_pkg.sv -----
// ----------------------------------------------------------------------------
// ndlp_pkg: shared types and constants of the node load-path loss judge
// Field widths, stream word layouts, configuration register indexes and the
// dead-count saturation limit.
// ----------------------------------------------------------------------------
package ndlp_pkg;

  localparam int NODE_W  = 10;
  localparam int MASK_W  = 3;
  localparam int DIAG_W  = 32;
  localparam int RATIO_W = 32;
  localparam int COUNT_W = 11;
  localparam int PROD_W  = 64;
  localparam int FRAC_SHIFT = 24;

  localparam logic [MASK_W-1:0]  MASK_ALL  = 3'b111;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Input word layout, lowest bit first.
  localparam int IN_NODE_LSB = 0;
  localparam int IN_MASK_LSB = IN_NODE_LSB + NODE_W;
  localparam int IN_DX_LSB   = IN_MASK_LSB + MASK_W;
  localparam int IN_DY_LSB   = IN_DX_LSB + DIAG_W;
  localparam int IN_DZ_LSB   = IN_DY_LSB + DIAG_W;
  localparam int IN_USED_W   = IN_DZ_LSB + DIAG_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OUT_JUDGED_BIT = 0;
  localparam int OUT_DEAD_BIT   = 1;
  localparam int OUT_MIN_LSB    = 2;
  localparam int OUT_CNT_LSB    = OUT_MIN_LSB + DIAG_W;
  localparam int OUT_USED_W     = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_RATIO = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_NEGATIVE  = 1'd1;
  localparam int CFG_DATA_W = 32;

endpackage

// ----- rtl/ndlp_ram.sv -----
// ----------------------------------------------------------------------------
// ndlp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. The read data
// register holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module ndlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/node_load_path_loss_judge_unit.sv -----
// ----------------------------------------------------------------------------
// node_load_path_loss_judge_unit: judges whether a node has lost its load path
// Keeps an intact reference stiffness per node and flags nodes whose minimum
// translational diagonal has dropped below a programmable fraction of it.
// ----------------------------------------------------------------------------
// Usage. Nodes arrive on the in_ stream, one word per node, with the first
// node of an operator pass marked in in_tuser. Each accepted word produces
// exactly one word on the out_ stream, in order. The cfg_ channel writes the
// threshold ratio (index 0, unsigned Q8.24, zero disarms the judgement) and
// the allow-negative flag (index 1); cfg_ready is always high, and the
// registers are meant to be written only while no node is in flight.
//
// Timing. The datapath is a four-register pipeline: the input register (which
// also reads the reference RAM), a reference stage, a product stage and the
// output register. One word can be accepted every cycle unless out_tready
// stalls the pipeline. The rate is set by the single read-modify-write of
// the reference RAM per node; a reference captured by one node is forwarded
// to the next word if it names the same node, so back-to-back words to one
// node behave as if processed in turn.
//
// Reset and stall. After rst_n the block sweeps all min(NODES, 1024) entries
// of the reference RAM to zero, one entry a cycle, with in_tready low; the
// config registers and the dead count clear at once. Each stage advances
// when the stage after it is empty or moving, so a stalled out_tready fills
// the pipeline bubbles first and only then drops in_tready.
// ----------------------------------------------------------------------------
module node_load_path_loss_judge_unit #(
  parameter int NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream. tdata fields from bit 0 up: node_index[9:0],
  // active_mask[2:0], diag_x[31:0], diag_y[31:0], diag_z[31:0], zero pad.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ndlp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser fields from bit 0 up: first_of_pass.
  input  logic                                in_tuser,
  // Result stream. tdata fields from bit 0 up: judged, node_dead,
  // min_diag[31:0], dead_count[10:0], zero pad.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ndlp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ndlp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ndlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Only the first 1024 nodes can be addressed by a 10-bit index.
  localparam int NODE_SPACE = 1 << ndlp_pkg::NODE_W;
  localparam int DEPTH = (NODES < NODE_SPACE) ? NODES : NODE_SPACE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [16:0]   NODES_L   = 17'(NODES);

  // ---------------------------------------------------------------- config
  logic [ndlp_pkg::RATIO_W-1:0] threshold_r;
  logic                         allow_neg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      allow_neg_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ndlp_pkg::CFG_THRESHOLD_RATIO: threshold_r <= cfg_data;
        ndlp_pkg::CFG_ALLOW_NEGATIVE:  allow_neg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- clear sweep
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // ------------------------------------------------------ stage handshakes
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic en_out, en_s3, en_s2, en_s1, in_fire;

  assign en_out   = !out_v_r || out_tready;
  assign en_s3    = !s3_v_r || en_out;
  assign en_s2    = !s2_v_r || en_s3;
  assign en_s1    = !s1_v_r || en_s2;
  assign in_tready = en_s1 && !clearing_r;
  assign in_fire  = in_tvalid && in_tready;

  // --------------------------------------------------- stage 1: input + RAM
  logic [ndlp_pkg::NODE_W-1:0]        s1_node_r;
  logic [ndlp_pkg::MASK_W-1:0]        s1_mask_r;
  logic signed [ndlp_pkg::DIAG_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic                               s1_first_r;
  logic                               byp_hit_r;
  logic [ndlp_pkg::DIAG_W-1:0]        byp_data_r;

  logic [ndlp_pkg::NODE_W-1:0] in_node;
  assign in_node = in_tdata[ndlp_pkg::IN_NODE_LSB +: ndlp_pkg::NODE_W];

  // RAM ports.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ndlp_pkg::DIAG_W-1:0] ram_wdata;
  logic [ndlp_pkg::DIAG_W-1:0] ram_rdata;

  // Stage 1 combinational judgement of the minimum and the reference.
  logic                               s1_judged;
  logic                               s1_in_store;
  logic signed [ndlp_pkg::DIAG_W-1:0] s1_min_xy, s1_min;
  logic [ndlp_pkg::DIAG_W-1:0]        s1_ref_raw, s1_ref;
  logic                               s1_capture;
  logic                               s1_move;

  assign s1_judged   = (s1_mask_r == ndlp_pkg::MASK_ALL);
  assign s1_in_store = ({7'd0, s1_node_r} < NODES_L);
  assign s1_min_xy   = (s1_dy_r < s1_dx_r) ? s1_dy_r : s1_dx_r;
  assign s1_min      = (s1_dz_r < s1_min_xy) ? s1_dz_r : s1_min_xy;
  assign s1_ref_raw  = !s1_in_store ? '0 : (byp_hit_r ? byp_data_r : ram_rdata);
  assign s1_capture  = s1_judged && s1_in_store && (s1_ref_raw == '0) &&
                       !s1_min[ndlp_pkg::DIAG_W-1] && (s1_min != '0);
  assign s1_ref      = s1_capture ? s1_min : s1_ref_raw;
  assign s1_move     = s1_v_r && en_s2;

  // The reference is captured as the node leaves stage 1, so it is written
  // exactly once even if the stage waits.
  assign ram_we    = clearing_r || (s1_move && s1_capture);
  assign ram_waddr = clearing_r ? clr_addr_r : s1_node_r[AW-1:0];
  assign ram_wdata = clearing_r ? '0 : s1_min;

  ndlp_ram #(
    .WIDTH (ndlp_pkg::DIAG_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_node[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_node_r  <= in_node;
      s1_mask_r  <= in_tdata[ndlp_pkg::IN_MASK_LSB +: ndlp_pkg::MASK_W];
      s1_dx_r    <= in_tdata[ndlp_pkg::IN_DX_LSB +: ndlp_pkg::DIAG_W];
      s1_dy_r    <= in_tdata[ndlp_pkg::IN_DY_LSB +: ndlp_pkg::DIAG_W];
      s1_dz_r    <= in_tdata[ndlp_pkg::IN_DZ_LSB +: ndlp_pkg::DIAG_W];
      s1_first_r <= in_tuser;
      // The RAM read in this cycle misses a capture written in the same
      // cycle, so that value is carried along beside the read data.
      byp_hit_r  <= s1_move && s1_capture && (s1_node_r == in_node);
      byp_data_r <= s1_min;
    end
  end

  // ------------------------------------------------ stage 2: reference
  logic                               s2_judged_r, s2_first_r;
  logic signed [ndlp_pkg::DIAG_W-1:0] s2_min_r;
  logic [ndlp_pkg::DIAG_W-1:0]        s2_ref_r;
  logic [ndlp_pkg::PROD_W-1:0]        s2_prod;

  assign s2_prod = ndlp_pkg::PROD_W'(threshold_r) * ndlp_pkg::PROD_W'(s2_ref_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_judged_r <= s1_judged;
      s2_first_r  <= s1_first_r;
      s2_min_r    <= s1_judged ? s1_min : '0;
      s2_ref_r    <= s1_ref;
    end
  end

  // -------------------------------------------------- stage 3: product
  logic                               s3_judged_r, s3_first_r, s3_ref_nz_r;
  logic signed [ndlp_pkg::DIAG_W-1:0] s3_min_r;
  logic [ndlp_pkg::PROD_W-1:0]        s3_prod_r;
  logic [ndlp_pkg::PROD_W-1:0]        s3_lhs;
  logic                               s3_nonpos, s3_armed, s3_dead;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en_s3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && en_s3) begin
      s3_judged_r <= s2_judged_r;
      s3_first_r  <= s2_first_r;
      s3_min_r    <= s2_min_r;
      s3_ref_nz_r <= (s2_ref_r != '0);
      s3_prod_r   <= s2_prod;
    end
  end

  // Exact compare: min * 2^24 < ratio * reference.
  assign s3_lhs    = {8'd0, s3_min_r, {ndlp_pkg::FRAC_SHIFT{1'b0}}};
  assign s3_nonpos = s3_min_r[ndlp_pkg::DIAG_W-1] || (s3_min_r == '0);
  assign s3_armed  = s3_judged_r && s3_ref_nz_r && (threshold_r != '0);
  assign s3_dead   = s3_armed && (s3_nonpos ? allow_neg_r : (s3_lhs < s3_prod_r));

  // ----------------------------------------------- output register + count
  logic                               out_judged_r, out_dead_r;
  logic signed [ndlp_pkg::DIAG_W-1:0] out_min_r;
  logic [ndlp_pkg::COUNT_W-1:0]       count_r, count_base, count_nxt;
  logic                               s3_move;

  assign s3_move    = s3_v_r && en_out;
  assign count_base = s3_first_r ? '0 : count_r;
  assign count_nxt  = (s3_dead && (count_base != ndlp_pkg::COUNT_MAX)) ?
                      count_base + ndlp_pkg::COUNT_W'(1) : count_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      count_r <= '0;
    end else begin
      if (en_out) begin
        out_v_r <= s3_v_r;
      end
      if (s3_move) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_judged_r <= s3_judged_r;
      out_dead_r   <= s3_dead;
      out_min_r    <= s3_min_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(ndlp_pkg::OUT_TDATA_W - ndlp_pkg::OUT_USED_W)'(0),
                       count_r, out_min_r, out_dead_r, out_judged_r};

endmodule

// ----- rtl/ndlp_checker.sv -----
// ----------------------------------------------------------------------------
// ndlp_checker: port-level checks of the node load-path loss judge
// Watches the top-level ports for reset behavior, result consistency and
// output stability under back-pressure.
// ----------------------------------------------------------------------------
module ndlp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ndlp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic out_judged, out_dead;
  logic [ndlp_pkg::DIAG_W-1:0] out_min;

  assign out_judged = out_tdata[ndlp_pkg::OUT_JUDGED_BIT];
  assign out_dead   = out_tdata[ndlp_pkg::OUT_DEAD_BIT];
  assign out_min    = out_tdata[ndlp_pkg::OUT_MIN_LSB +: ndlp_pkg::DIAG_W];

  // The reference store is swept after reset, so no word is taken at once.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input accepted before the reference store was cleared");

  // Only a judged node can be dead.
  a_dead_needs_judged: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_judged || !out_dead))
    else $error("dead node reported without judgement");

  // A node that is not judged reports a zero minimum.
  a_unjudged_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_judged) |-> (out_min == '0))
    else $error("nonzero minimum on an unjudged node");

  // A stalled result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind node_load_path_loss_judge_unit ndlp_checker u_ndlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/node_load_path_loss_judge_unit_tb.sv -----
// ----------------------------------------------------------------------------
// node_load_path_loss_judge_unit_tb: self-checking bench for the load-path judge
// Streams node words through the block and keeps its own model of the intact
// reference store, the pass dead count and both registers. The model predicts
// every result word at input acceptance. A directed opening covers capture, the
// exact threshold, non-positive minima, every active mask and the register
// extremes. Random phases with varied idling and register settings follow, and
// a closing pass of non-positive minima on one referenced node runs up the
// dead count.
// ----------------------------------------------------------------------------
module node_load_path_loss_judge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ndlp_pkg::*;

  localparam int TB_NODES = 1024;
  localparam logic signed [DIAG_W-1:0] ONE = 32'sh0001_0000;  // 1.0 in Q16.16

  // One node word as it travels on the input stream.
  typedef struct {
    logic [NODE_W-1:0]        node;
    logic [MASK_W-1:0]        mask;
    logic signed [DIAG_W-1:0] dx;
    logic signed [DIAG_W-1:0] dy;
    logic signed [DIAG_W-1:0] dz;
    logic                     first;
  } node_word_t;

  // One verdict word as it comes back on the result stream.
  typedef struct {
    logic                     judged;
    logic                     dead;
    logic signed [DIAG_W-1:0] min_diag;
    logic [COUNT_W-1:0]       count;
  } verdict_t;

  typedef struct {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // Model state: the reference store, the running count and the registers.
  logic [DIAG_W-1:0]  intact_ref [TB_NODES];
  logic [COUNT_W-1:0] pass_dead = '0;
  logic [RATIO_W-1:0] thr_ratio = '0;
  logic               allow_neg = 1'b0;

  node_word_t   node_q[$];      // node words waiting to be driven
  verdict_t     verdict_q[$];   // predicted verdicts, oldest first
  reg_write_t   reg_q[$];       // pending register writes
  node_word_t   on_bus;         // the word currently offered on in_tdata
  reg_write_t   reg_on_bus;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int errors        = 0;
  int nodes_sent    = 0;
  int nodes_judged  = 0;
  int nodes_dead    = 0;
  int count_pinned  = 0;
  int reg_writes    = 0;

  node_load_path_loss_judge_unit #(
    .NODES(TB_NODES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (intact_ref[i]) intact_ref[i] = '0;
  end

  // Judges one node against the model state and advances that state. The
  // threshold test is exact: min * 2^24 against ratio * reference in 64 bits.
  function automatic verdict_t judge_node(node_word_t w);
    verdict_t          v;
    logic [DIAG_W-1:0] ref_val;
    logic signed [DIAG_W-1:0] m;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    v = '{default: '0};
    if (w.first) pass_dead = '0;
    if (w.mask == MASK_ALL) begin
      ref_val = (w.node < TB_NODES) ? intact_ref[w.node] : '0;
      m = w.dx;
      if (w.dy < m) m = w.dy;
      if (w.dz < m) m = w.dz;
      v.judged = 1'b1;
      v.min_diag = m;
      // The first positive minimum becomes the reference and is judged at once.
      if (ref_val == '0 && m > 0 && w.node < TB_NODES) begin
        ref_val = m;
        intact_ref[w.node] = m;
      end
      if (thr_ratio != '0 && ref_val != '0) begin
        if (m <= 0) begin
          v.dead = allow_neg;
        end else begin
          lhs = {8'd0, m, 24'd0};
          rhs = {32'd0, thr_ratio} * {32'd0, ref_val};
          v.dead = (lhs < rhs);
        end
      end
      if (v.dead && pass_dead < COUNT_MAX) pass_dead = pass_dead + 1'b1;
    end
    v.count = pass_dead;
    return v;
  endfunction

  // Input and register driver. A word stays on the bus until it is taken;
  // the verdict is predicted at the edge where the handshake completes.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      verdict_t v;
      v = judge_node(on_bus);
      verdict_q.push_back(v);
      nodes_sent++;
      if (v.judged) nodes_judged++;
      if (v.dead) nodes_dead++;
      if (v.count == COUNT_MAX) count_pinned++;
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (node_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        on_bus = node_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'({on_bus.dz, on_bus.dy, on_bus.dx, on_bus.mask, on_bus.node});
        in_tuser  <= on_bus.first;
      end else begin
        in_tvalid <= 1'b0;
      end
    end

    if (cfg_valid && cfg_ready) begin
      case (reg_on_bus.index)
        CFG_THRESHOLD_RATIO: thr_ratio = reg_on_bus.data;
        CFG_ALLOW_NEGATIVE:  allow_neg = reg_on_bus.data[0];
        default: ;
      endcase
      reg_writes++;
    end
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_q.size() != 0) begin
        reg_on_bus = reg_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= reg_on_bus.index;
        cfg_data  <= reg_on_bus.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // Result monitor. The ready line stalls at random; each accepted word is
  // compared field by field with the oldest predicted verdict.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      verdict_t want;
      verdict_t got;
      got.judged   = out_tdata[OUT_JUDGED_BIT];
      got.dead     = out_tdata[OUT_DEAD_BIT];
      got.min_diag = out_tdata[OUT_MIN_LSB +: DIAG_W];
      got.count    = out_tdata[OUT_CNT_LSB +: COUNT_W];
      if (verdict_q.size() == 0) begin
        $display("%t: result word with none pending, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got.judged !== want.judged) begin
          $display("%t: judged expected %0d got %0d", $time, want.judged, got.judged);
          errors++;
        end
        if (got.dead !== want.dead) begin
          $display("%t: node_dead expected %0d got %0d", $time, want.dead, got.dead);
          errors++;
        end
        if (got.min_diag !== want.min_diag) begin
          $display("%t: min_diag expected %h got %h", $time, want.min_diag, got.min_diag);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%t: dead_count expected %0d got %0d", $time, want.count, got.count);
          errors++;
        end
      end
    end
  end

  function automatic node_word_t node_word(int unsigned node, int unsigned mask,
                                           int dx, int dy, int dz, bit first);
    node_word_t w;
    w.node = NODE_W'(node);
    w.mask = MASK_W'(mask);
    w.dx = dx;
    w.dy = dy;
    w.dz = dz;
    w.first = first;
    return w;
  endfunction

  // Random node word. Most words go to a small set of nodes so references get
  // captured and revisited, and about two in five minima land near the live threshold.
  function automatic node_word_t make_random_node();
    node_word_t        w;
    logic [PROD_W-1:0] prod;
    logic [DIAG_W-1:0] base;
    int                mn;
    int                pick;
    int                vals[3];
    pick = $urandom_range(99);
    if (pick < 75)      w.node = NODE_W'($urandom_range(15));
    else if (pick < 80) w.node = '1;
    else                w.node = NODE_W'($urandom);
    w.mask  = ($urandom_range(99) < 85) ? MASK_ALL : MASK_W'($urandom_range(6));
    w.first = ($urandom_range(39) == 0);
    base = intact_ref[w.node];
    if (base == '0) base = $urandom_range(32'h0040_0000, 1);
    pick = $urandom_range(99);
    if (pick < 20) begin
      w.dx = $urandom;
      w.dy = $urandom;
      w.dz = $urandom;
    end else begin
      if (pick < 60) begin
        // Within a couple of LSBs of the dead threshold.
        prod = ({32'd0, thr_ratio} * {32'd0, base}) >> FRAC_SHIFT;
        if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
        mn = int'(prod[31:0]) + int'($urandom_range(4)) - 2;
      end else if (pick < 75) begin
        // Some fraction of the reference, in sixteenths up to twice it.
        prod = ({32'd0, base} * $urandom_range(32)) >> 4;
        if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
        mn = int'(prod[31:0]);
      end else if (pick < 85) begin
        mn = -int'($urandom_range(3 * 65536));
        if ($urandom_range(9) == 0) mn = int'(32'h8000_0000);
      end else begin
        mn = int'($urandom_range(32'h7FFF_FFFF, 1));
      end
      for (int k = 0; k < 3; k++) begin
        vals[k] = ($urandom_range(3) == 0) ? mn : int'($urandom);
        if (vals[k] < mn) vals[k] = mn;
      end
      vals[$urandom_range(2)] = mn;
      w.dx = vals[0];
      w.dy = vals[1];
      w.dz = vals[2];
    end
    return w;
  endfunction

  // The stimulus side works on falling edges so it never races the driver.
  // Only a few words are kept queued, so random words see a current store.
  task automatic queue_node(node_word_t w);
    while (node_q.size() > 4) @(negedge clk);
    node_q.push_back(w);
  endtask

  // Registers change only with the pipeline empty: nothing queued, nothing on
  // the bus and every predicted verdict already returned.
  task automatic set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    reg_write_t r;
    while (node_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    r.index = index;
    r.data = data;
    reg_q.push_back(r);
    while (reg_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening with a half-reference threshold and negatives allowed.
    set_reg(CFG_THRESHOLD_RATIO, 32'h0080_0000);
    set_reg(CFG_ALLOW_NEGATIVE, 32'd1);
    queue_node(node_word(0, MASK_ALL, ONE, ONE, ONE, 1'b1));          // capture 1.0
    queue_node(node_word(0, MASK_ALL, ONE, 32'sh8000, ONE, 1'b0));    // exactly at threshold
    queue_node(node_word(0, MASK_ALL, ONE, ONE, 32'sh7FFF, 1'b0));    // just below it
    queue_node(node_word(0, MASK_ALL, 0, ONE, ONE, 1'b0));            // zero minimum
    queue_node(node_word(0, MASK_ALL, -1, ONE, ONE, 1'b0));
    queue_node(node_word(0, MASK_ALL, int'(32'h8000_0000), 32'h7FFF_FFFF, ONE, 1'b0));
    queue_node(node_word(1, MASK_ALL, -ONE, ONE, ONE, 1'b0));         // negative, no reference
    for (int m = 0; m < 7; m++)                                       // every partial mask
      queue_node(node_word(1, m, ONE, ONE, ONE, m == 0));
    queue_node(node_word(1023, MASK_ALL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    queue_node(node_word(1023, MASK_ALL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0));
    // Back-to-back words on one node: capture, then judged against it at once.
    queue_node(node_word(5, MASK_ALL, 3 * ONE, 2 * ONE, 5 * ONE, 1'b0));
    queue_node(node_word(5, MASK_ALL, ONE - 1, 2 * ONE, 5 * ONE, 1'b0));
    queue_node(node_word(5, MASK_ALL, 5 * ONE, 5 * ONE, ONE, 1'b0));
    queue_node(node_word(1023, MASK_ALL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));

    // Largest ratio with negatives not allowed.
    set_reg(CFG_THRESHOLD_RATIO, 32'hFFFF_FFFF);
    set_reg(CFG_ALLOW_NEGATIVE, 32'd0);
    queue_node(node_word(0, MASK_ALL, -5, ONE, ONE, 1'b0));
    queue_node(node_word(1023, MASK_ALL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    // A zero ratio disarms the judgement altogether.
    set_reg(CFG_THRESHOLD_RATIO, 32'd0);
    queue_node(node_word(0, MASK_ALL, 1, 1, 1, 1'b0));
    // Smallest nonzero ratio against the largest reference.
    set_reg(CFG_THRESHOLD_RATIO, 32'd1);
    set_reg(CFG_ALLOW_NEGATIVE, 32'd1);
    queue_node(node_word(1023, MASK_ALL, 1, ONE, ONE, 1'b0));
    queue_node(node_word(1023, MASK_ALL, 32'h7F, ONE, ONE, 1'b0));
    queue_node(node_word(1023, MASK_ALL, 32'h80, ONE, ONE, 1'b0));

    // Random phases, each with its own idling pattern and register setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_reg(CFG_THRESHOLD_RATIO, 32'h0080_0000);
          set_reg(CFG_ALLOW_NEGATIVE, 32'd1);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          set_reg(CFG_THRESHOLD_RATIO, $urandom_range(32'h0180_0000, 32'h0010_0000));
          set_reg(CFG_ALLOW_NEGATIVE, 32'd0);
          src_idle_pct = 78;
          sink_stall_pct = 0;
        end
        2: begin
          set_reg(CFG_THRESHOLD_RATIO, 32'hFFFF_FFFF);
          set_reg(CFG_ALLOW_NEGATIVE, 32'd1);
          src_idle_pct = 0;
          sink_stall_pct = 78;
        end
        default: begin
          set_reg(CFG_THRESHOLD_RATIO, $urandom_range(32'h0100_0000, 1));
          set_reg(CFG_ALLOW_NEGATIVE, $urandom_range(1));
          src_idle_pct = 25;
          sink_stall_pct = 25;
        end
      endcase
      repeat (420) queue_node(make_random_node());
    end

    // A closing pass of non-positive minima on a referenced node, so every
    // word is dead and the dead count climbs word after word.
    set_reg(CFG_THRESHOLD_RATIO, 32'hFFFF_FFFF);
    set_reg(CFG_ALLOW_NEGATIVE, 32'd1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    for (int n = 0; n < 100; n++)
      queue_node(node_word(0, MASK_ALL, -int'($urandom_range(4 * 65536)),
                           int'($urandom), int'($urandom), n == 0));
    queue_node(node_word(0, MASK_ALL, -1, ONE, ONE, 1'b1));

    // Let everything drain, then keep watching the result stream for any
    // word it should not produce.
    while (node_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    for (waited = 0; waited < 20; waited++) @(negedge clk);

    $display("Sent %0d nodes: %0d judged, %0d dead, dead count held at its limit %0d times.",
             nodes_sent, nodes_judged, nodes_dead, count_pinned);
    $display("%0d register writes covered zero, minimum and maximum ratios.", reg_writes);
    if (errors == 0) begin
      $display("node_load_path_loss_judge_unit regression: pass");
    end else begin
      $display("node_load_path_loss_judge_unit regression: fail");
    end
    $finish;
  end

  // Watchdog. A correct run finishes in well under a tenth of this.
  initial begin
    #5ms;
    $display("Timed out with %0d verdicts outstanding.", verdict_q.size());
    $display("node_load_path_loss_judge_unit regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ndlp_pkg.sv
rtl/ndlp_ram.sv
rtl/node_load_path_loss_judge_unit.sv
rtl/ndlp_checker.sv
tb/node_load_path_loss_judge_unit_tb.sv
